@@ rtl/mtfh_pkg.sv @@
// Shared types and constants for the move-to-front history list.
package mtfh_pkg;

   localparam int CSR_BITS       = 7;
   localparam int POS_OUT_BITS   = 6;
   localparam int COUNT_OUT_BITS = 7;

   typedef struct packed {
      logic                      ignored;
      logic                      hit;
      logic [POS_OUT_BITS-1:0]   hit_position;
      logic                      evicted;
      logic [COUNT_OUT_BITS-1:0] entry_count;
      logic                      list_empty;
   } rsp_type;

endpackage

@@ rtl/mtfh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mtfh_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/mtfh_seq.sv @@
// Sequencer: serial key search with one comparator, then a one-entry-a-cycle shift.
module mtfh_seq #(
   parameter int DEPTH      = 64,
   parameter int KEY_BITS   = 64,
   parameter int STAMP_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [KEY_BITS-1:0]              req_key,
   input  logic                             req_key_empty,
   input  logic [STAMP_BITS-1:0]            req_stamp,
   input  logic [$clog2(DEPTH+1)-1:0]       cap,
   input  logic                             cap_wr,
   input  logic [$clog2(DEPTH+1)-1:0]       cap_new,
   output logic                             busy,
   output logic                             rsp_strobe,
   output mtfh_pkg::rsp_type                rsp,
   output logic                             ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]         ram_wr_addr,
   output logic [KEY_BITS+STAMP_BITS-1:0]   ram_wr_data,
   output logic [$clog2(DEPTH)-1:0]         ram_rd_addr,
   input  logic [KEY_BITS+STAMP_BITS-1:0]   ram_rd_data
);

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH+1);
   localparam int PW  = (AW > mtfh_pkg::POS_OUT_BITS) ? AW : mtfh_pkg::POS_OUT_BITS;
   localparam int OW  = (CW > mtfh_pkg::COUNT_OUT_BITS) ? CW : mtfh_pkg::COUNT_OUT_BITS;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_SHIFT  = 2'd2;
   localparam logic [1:0] ST_FRONT  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [STAMP_BITS-1:0] stamp_ff, stamp_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         srch_ff, srch_in;
   logic [AW-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]         sh_dst_ff, sh_dst_in;
   logic                  wr_pend_ff, wr_pend_in;
   logic [AW-1:0]         wr_addr_ff, wr_addr_in;
   logic                  hit_ff, hit_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic                  evict_ff, evict_in;

   logic                  match;
   logic                  last;
   logic                  miss_evict;
   logic [CW-1:0]         miss_count;
   logic [AW-1:0]         miss_top;

   // response fields, widened before truncation to the port widths
   logic                  r_ignored, r_hit, r_evicted;
   logic [AW-1:0]         r_pos;
   logic [CW-1:0]         r_count;
   logic [PW-1:0]         pos_w;
   logic [OW-1:0]         count_w;

   assign match      = cmp_valid_ff && (ram_rd_data[KEY_BITS-1:0] == key_ff);
   assign last       = cmp_valid_ff && ((CW'(cmp_idx_ff) + CW'(1)) == count_ff);
   assign miss_evict = (count_ff >= cap);
   assign miss_count = miss_evict ? count_ff : (count_ff + CW'(1));
   assign miss_top   = AW'(miss_count - CW'(1));

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      stamp_in     = stamp_ff;
      count_in     = count_ff;
      srch_in      = srch_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = 1'b0;
      sh_dst_in    = sh_dst_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      hit_in       = hit_ff;
      pos_in       = pos_ff;
      evict_in     = evict_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wr_addr_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_addr  = srch_ff;
      rsp_strobe   = 1'b0;
      r_ignored    = 1'b0;
      r_hit        = 1'b0;
      r_evicted    = 1'b0;
      r_pos        = '0;
      r_count      = count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cap_wr && (count_ff > cap_new)) begin
               count_in = cap_new;
            end
            if (start) begin
               if ((cap == '0) || req_key_empty) begin
                  rsp_strobe = 1'b1;
                  r_ignored  = 1'b1;
               end else begin
                  state_in = ST_SEARCH;
                  key_in   = req_key;
                  stamp_in = req_stamp;
                  srch_in  = '0;
               end
            end
         end
         ST_SEARCH: begin
            if (match) begin
               if (cmp_idx_ff == '0) begin
                  // already at the front: nothing moves
                  rsp_strobe = 1'b1;
                  r_hit      = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  hit_in    = 1'b1;
                  pos_in    = cmp_idx_ff;
                  evict_in  = 1'b0;
                  sh_dst_in = cmp_idx_ff;
                  state_in  = ST_SHIFT;
               end
            end else if (last || (!cmp_valid_ff && (count_ff == '0))) begin
               hit_in    = 1'b0;
               pos_in    = '0;
               evict_in  = miss_evict;
               count_in  = miss_count;
               sh_dst_in = miss_top;
               state_in  = (miss_top == '0) ? ST_FRONT : ST_SHIFT;
            end else begin
               ram_rd_addr  = srch_ff;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = srch_ff;
               srch_in      = srch_ff + AW'(1);
            end
         end
         ST_SHIFT: begin
            // write the entry read last cycle one place back
            ram_wr_en = wr_pend_ff;
            if (sh_dst_ff != '0) begin
               ram_rd_addr = sh_dst_ff - AW'(1);
               wr_addr_in  = sh_dst_ff;
               wr_pend_in  = 1'b1;
               sh_dst_in   = sh_dst_ff - AW'(1);
            end else begin
               state_in = ST_FRONT;
            end
         end
         ST_FRONT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
            ram_wr_data = {stamp_ff, key_ff};
            rsp_strobe  = 1'b1;
            r_hit       = hit_ff;
            r_pos       = pos_ff;
            r_evicted   = evict_ff;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pos_w             = PW'(r_pos);
      count_w           = OW'(r_count);
      rsp.ignored       = r_ignored;
      rsp.hit           = r_hit;
      rsp.hit_position  = pos_w[mtfh_pkg::POS_OUT_BITS-1:0];
      rsp.evicted       = r_evicted;
      rsp.entry_count   = count_w[mtfh_pkg::COUNT_OUT_BITS-1:0];
      rsp.list_empty    = (r_count == '0);
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         wr_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         wr_pend_ff   <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      stamp_ff   <= stamp_in;
      srch_ff    <= srch_in;
      cmp_idx_ff <= cmp_idx_in;
      sh_dst_ff  <= sh_dst_in;
      wr_addr_ff <= wr_addr_in;
      hit_ff     <= hit_in;
      pos_ff     <= pos_in;
      evict_ff   <= evict_in;
   end

endmodule

@@ rtl/move_to_front_history_list_top.sv @@
// Top level of the move-to-front history list: capacity register, response register, core.
//
// Usage notes
// - Request channel: drive req_key, req_key_empty and req_stamp with start high; the
//   request is taken at a rising edge where start is high and busy is low.
// - Response channel: one response per request, shown for exactly one cycle with
//   rsp_valid high. The receiver cannot stall, so it must capture it then.
// - csr_we/csr_wdata write the capacity (values above DEPTH saturate). Writing it
//   trims the list to the new capacity; zero empties it. Write only while idle.
// - Ignored requests (capacity zero or empty key) answer in the cycle after acceptance
//   and never raise busy.
// - Other requests walk the list one entry a cycle through the single key
//   comparator, then move entries back one place a cycle through the RAM port
//   and write key and stamp at the front; a hit at the front moves nothing.
//   busy drops while the response shows, so the next request can go in at its edge.
// - The list lives in one RAM of DEPTH words holding key and stamp together.
// - Synchronous active-high reset empties the list and zeroes the capacity; the
//   RAM contents are left as they are, entries beyond the count are never used.
module move_to_front_history_list_top #(
   parameter int DEPTH      = 64,
   parameter int KEY_BITS   = 64,
   parameter int STAMP_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [KEY_BITS-1:0]                     req_key,
   input  logic                                    req_key_empty,
   input  logic [STAMP_BITS-1:0]                   req_stamp,
   input  logic                                    csr_we,
   input  logic [mtfh_pkg::CSR_BITS-1:0]           csr_wdata,
   output logic                                    rsp_valid,
   output logic                                    rsp_ignored,
   output logic                                    rsp_hit,
   output logic [mtfh_pkg::POS_OUT_BITS-1:0]       rsp_hit_position,
   output logic                                    rsp_evicted,
   output logic [mtfh_pkg::COUNT_OUT_BITS-1:0]     rsp_entry_count,
   output logic                                    rsp_list_empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);
   localparam int XW = (CW > mtfh_pkg::CSR_BITS) ? CW : mtfh_pkg::CSR_BITS;
   localparam int WW = KEY_BITS + STAMP_BITS;

   logic [CW-1:0]        cap_ff, cap_in;
   logic [XW-1:0]        wdata_x;
   logic [XW-1:0]        cap_sat;
   logic                 rsp_valid_ff;
   mtfh_pkg::rsp_type    rsp_ff;

   logic                 seq_strobe;
   mtfh_pkg::rsp_type    seq_rsp;
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [WW-1:0]        ram_wr_data;
   logic [AW-1:0]        ram_rd_addr;
   logic [WW-1:0]        ram_rd_data;

   // saturate the written capacity at the list depth
   assign wdata_x = XW'(csr_wdata);
   assign cap_sat = (wdata_x > XW'(DEPTH)) ? XW'(DEPTH) : wdata_x;
   assign cap_in  = csr_we ? cap_sat[CW-1:0] : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= seq_strobe;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_strobe) begin
         rsp_ff <= seq_rsp;
      end
   end

   mtfh_seq #(
      .DEPTH      (DEPTH),
      .KEY_BITS   (KEY_BITS),
      .STAMP_BITS (STAMP_BITS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_key       (req_key),
      .req_key_empty (req_key_empty),
      .req_stamp     (req_stamp),
      .cap           (cap_ff),
      .cap_wr        (csr_we),
      .cap_new       (cap_sat[CW-1:0]),
      .busy          (busy),
      .rsp_strobe    (seq_strobe),
      .rsp           (seq_rsp),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data)
   );

   mtfh_ram #(
      .WIDTH (WW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ignored      = rsp_ff.ignored;
   assign rsp_hit          = rsp_ff.hit;
   assign rsp_hit_position = rsp_ff.hit_position;
   assign rsp_evicted      = rsp_ff.evicted;
   assign rsp_entry_count  = rsp_ff.entry_count;
   assign rsp_list_empty   = rsp_ff.list_empty;

endmodule

@@ rtl/mtfh_checker.sv @@
// Port-level checks on the history list top level, bound in below.
module mtfh_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                req_key_empty,
   input logic                                rsp_valid,
   input logic                                rsp_ignored,
   input logic                                rsp_hit,
   input logic [mtfh_pkg::POS_OUT_BITS-1:0]   rsp_hit_position,
   input logic                                rsp_evicted,
   input logic                                rsp_list_empty
);

   // an empty key is answered as ignored in the very next cycle
   a_empty_key_ignored: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_key_empty |=> rsp_valid && rsp_ignored)
      else $error("empty key request not answered as ignored");

   a_ignored_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ignored |-> !rsp_hit && !rsp_evicted && (rsp_hit_position == '0))
      else $error("ignored response carries hit or eviction");

   a_evict_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_evicted || !rsp_hit) |-> !rsp_hit && (rsp_hit_position == '0))
      else $error("miss response with hit data");

   // a request that was not ignored always leaves at least one entry
   a_list_filled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ignored |-> !rsp_list_empty)
      else $error("list empty after a taken request");

endmodule

bind move_to_front_history_list_top mtfh_checker u_mtfh_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_key_empty    (req_key_empty),
   .rsp_valid        (rsp_valid),
   .rsp_ignored      (rsp_ignored),
   .rsp_hit          (rsp_hit),
   .rsp_hit_position (rsp_hit_position),
   .rsp_evicted      (rsp_evicted),
   .rsp_list_empty   (rsp_list_empty)
);
